// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

// ===== src/mwee_pkg.sv =====
package mwee_pkg;

	localparam int TICK_W           = 14;
	localparam int DEF_ADDR_BITS    = 7;
	localparam int DEF_WORD_BITS    = 8;
	localparam int DEF_SHIFT_BITS   = 16;
	localparam int DEF_DEPTH        = 128;
	localparam logic [TICK_W-1:0] RST_WRITE_TICKS = 14'd1750;
	localparam logic [TICK_W-1:0] RST_ERASE_TICKS = 14'd1000;
	localparam logic [TICK_W-1:0] RST_BULK_TICKS  = 14'd8000;

	// configuration register indexes
	localparam logic [1:0] CFG_WRITE_BUSY = 2'd0;
	localparam logic [1:0] CFG_ERASE_BUSY = 2'd1;
	localparam logic [1:0] CFG_BULK_BUSY  = 2'd2;

	// command opcode field
	localparam logic [1:0] CMD_EXT   = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_ERASE = 2'd3;

	// extended command selector (top two address bits)
	localparam logic [1:0] SUB_LOCK   = 2'd0;
	localparam logic [1:0] SUB_WRALL  = 2'd1;
	localparam logic [1:0] SUB_ERAL   = 2'd2;
	localparam logic [1:0] SUB_UNLOCK = 2'd3;

	typedef enum logic [1:0] {
		OP_CS   = 2'd0,
		OP_CLK  = 2'd1,
		OP_DI   = 2'd2,
		OP_TICK = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		BUSY_NONE,
		BUSY_WRITE,
		BUSY_ERASE,
		BUSY_BULK
	} busy_sel_t;

	typedef struct packed {
		logic      item_load;
		logic      set_cs;
		logic      set_clk;
		logic      set_di;
		logic      fresh_set;
		logic      fresh_clr;
		logic      tick;
		logic      sh_clr;
		logic      sh_in;
		logic      sh_left;
		logic      rd_load;
		logic      run;
		logic      lock_set;
		logic      lock_clr;
		busy_sel_t busy_sel;
		logic      mem_wr;
		logic      mem_ones;
		logic      fill_start;
		logic      fill_ones;
		logic      fill_step;
	} mwee_cmd_t;

	typedef struct packed {
		op_t        opcode;
		logic       level;
		logic       cs;
		logic       clk;
		logic       di;
		logic       fresh;
		logic       busy_zero;
		logic       cmd_full;
		logic       word_full;
		logic       rd_first;
		logic [1:0] cmd_op;
		logic [1:0] cmd_sub;
		logic       lock;
		logic       shift_msb;
		logic       fill_last;
	} mwee_status_t;

endpackage

// ===== src/microwire_serial_eeprom.sv =====
// Three-wire serial EEPROM model in logic, DEPTH words of WORD_BITS bits.
//
// Input channel (in_valid/in_ready, opcode, level): one transaction per pin
// change (chip select, clock, data in) or per one-microsecond tick. Output
// channel (out_valid/out_ready, data_out, ready_res): exactly one transaction
// per input transaction, the pin state after that item is applied.
// Configuration port (cfg_wen, cfg_index, cfg_data): single-cycle writes of
// the write, erase and bulk busy durations; index 3 is ignored.
//
// Each item is latched, executed and its result loaded. A clock edge adds a
// decode step in command mode, a commit step in write mode and a fetch step
// at a read word's first bit; a single erase adds decode and write steps;
// write-all, erase-all sweep the words one per cycle on the single write port.
// The result register sits between the two channels: a new item is taken
// while the previous result is still being handed off, but a stalled
// receiver holds the block once that result register is full.
// Reset: all words read as all ones (per-word valid bits, cleared at once),
// write lock set, busy counter zero, busy durations back to 1750/1000/8000.
module microwire_serial_eeprom import mwee_pkg::*; #(
	parameter int ADDR_BITS  = DEF_ADDR_BITS,
	parameter int WORD_BITS  = DEF_WORD_BITS,
	parameter int SHIFT_BITS = DEF_SHIFT_BITS,
	parameter int DEPTH      = DEF_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        opcode,
	input  logic              level,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              data_out,
	output logic              ready_res,
	input  logic              cfg_wen,
	input  logic [1:0]        cfg_index,
	input  logic [TICK_W-1:0] cfg_data
);

	`include "assert_macros.svh"

	mwee_cmd_t    cmd;
	mwee_status_t st;

	// Sequencer: walks each transaction through execute, command decode,
	// memory access and result load.
	mwee_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.data_out  (data_out),
		.ready_res (ready_res),
		.st        (st),
		.cmd       (cmd)
	);

	// Datapath: pin levels, shift register, address, lock, busy counter,
	// busy-duration registers and the word memory.
	mwee_dp #(
		.ADDR_BITS  (ADDR_BITS),
		.WORD_BITS  (WORD_BITS),
		.SHIFT_BITS (SHIFT_BITS),
		.DEPTH      (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.opcode    (opcode),
		.level     (level),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st)
	);

	// Never accept while a result sits stalled in the output register.
	`ASSERT_CLK(a_no_accept_on_stall, clk, arst_n, in_ready |-> (!out_valid || out_ready), "accept while result stalled")
	// Drop programming while locked: no single write or bulk fill may start.
	`ASSERT_NEVER(a_wr_locked, clk, arst_n, (cmd.mem_wr || cmd.fill_start) && st.lock, "memory programmed while locked")
	// Hold off the next transaction in the cycle right after an accept.
	`ASSERT_CLK(a_one_in_flight, clk, arst_n, (in_valid && in_ready) |=> !in_ready, "back-to-back accept")

endmodule

// ===== src/mwee_dp.sv =====
module mwee_dp import mwee_pkg::*; #(
	parameter int ADDR_BITS  = DEF_ADDR_BITS,
	parameter int WORD_BITS  = DEF_WORD_BITS,
	parameter int SHIFT_BITS = DEF_SHIFT_BITS,
	parameter int DEPTH      = DEF_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          opcode,
	input  logic                level,
	input  logic                cfg_wen,
	input  logic [1:0]          cfg_index,
	input  logic [TICK_W-1:0]   cfg_data,
	input  mwee_cmd_t           cmd,
	output mwee_status_t        st
);

	localparam int MEM_AW    = $clog2(DEPTH);
	localparam int RED_STEPS = (ADDR_BITS > MEM_AW) ? (ADDR_BITS - MEM_AW + 1) : 1;
	localparam int BC_MAX    = ((2 + ADDR_BITS) > WORD_BITS) ? (2 + ADDR_BITS) : WORD_BITS;
	localparam int BC_W      = $clog2(BC_MAX + 1);

	op_t                   opcode_q;
	logic                  level_q;
	logic                  cs_q, clk_q, di_q, fresh_q, lock_q;
	logic [SHIFT_BITS-1:0] shift_q;
	logic [BC_W-1:0]       bc_q;
	logic [ADDR_BITS-1:0]  addr_q;
	logic [TICK_W-1:0]     busy_q;
	logic [TICK_W-1:0]     wr_ticks_q, er_ticks_q, bulk_ticks_q;
	logic [WORD_BITS-1:0]  fill_data_q;
	logic [MEM_AW-1:0]     sweep_q;
	logic [DEPTH-1:0]      valid_q;
	logic [WORD_BITS-1:0]  mem [DEPTH];
	logic [WORD_BITS-1:0]  rdata_q;

	logic [MEM_AW-1:0]                idx;
	logic [WORD_BITS+SHIFT_BITS-1:0]  low_ext, load_ext;
	logic [WORD_BITS-1:0]             shift_word;
	logic [SHIFT_BITS-1:0]            load_val;
	logic [BC_W-1:0]                  bc_rd_next;
	logic                             wr_en;
	logic [MEM_AW-1:0]                waddr;
	logic [WORD_BITS-1:0]             wdata;

	// Reduce the address modulo DEPTH by restoring subtraction of shifted copies.
	always_comb begin : addr_reduce
		logic [31:0] red;
		red = 32'(addr_q);
		for (int k = RED_STEPS - 1; k >= 0; k--) begin
			if (red >= (32'(DEPTH) << k)) begin
				red = red - (32'(DEPTH) << k);
			end
		end
		idx = red[MEM_AW-1:0];
	end

	assign low_ext    = {{WORD_BITS{1'b0}}, shift_q};
	assign shift_word = low_ext[WORD_BITS-1:0];
	assign load_ext   = {rdata_q, {SHIFT_BITS{1'b0}}};
	assign load_val   = load_ext[WORD_BITS+SHIFT_BITS-1 -: SHIFT_BITS];
	assign bc_rd_next = (bc_q == BC_W'(WORD_BITS - 1)) ? '0 : bc_q + 1'b1;

	assign wr_en = cmd.mem_wr | cmd.fill_step;
	assign waddr = cmd.fill_step ? sweep_q : idx;
	assign wdata = cmd.fill_step ? fill_data_q : (cmd.mem_ones ? '1 : shift_word);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q         <= 1'b0;
			clk_q        <= 1'b0;
			di_q         <= 1'b0;
			fresh_q      <= 1'b0;
			lock_q       <= 1'b1;
			shift_q      <= '0;
			bc_q         <= '0;
			addr_q       <= '0;
			busy_q       <= '0;
			sweep_q      <= '0;
			valid_q      <= '0;
			wr_ticks_q   <= RST_WRITE_TICKS;
			er_ticks_q   <= RST_ERASE_TICKS;
			bulk_ticks_q <= RST_BULK_TICKS;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					CFG_WRITE_BUSY: wr_ticks_q   <= cfg_data;
					CFG_ERASE_BUSY: er_ticks_q   <= cfg_data;
					CFG_BULK_BUSY:  bulk_ticks_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.set_cs)    cs_q <= level_q;
			if (cmd.set_clk)   clk_q <= level_q;
			if (cmd.set_di)    di_q <= level_q;
			if (cmd.fresh_set) fresh_q <= 1'b1;
			if (cmd.fresh_clr) fresh_q <= 1'b0;
			if (cmd.lock_set)  lock_q <= 1'b1;
			if (cmd.lock_clr)  lock_q <= 1'b0;

			if (cmd.tick && busy_q != '0) begin
				busy_q <= busy_q - 1'b1;
			end
			unique case (cmd.busy_sel)
				BUSY_WRITE: busy_q <= wr_ticks_q;
				BUSY_ERASE: busy_q <= er_ticks_q;
				BUSY_BULK:  busy_q <= bulk_ticks_q;
				BUSY_NONE:  ;
			endcase

			if (cmd.run) begin
				bc_q   <= '0;
				addr_q <= shift_q[ADDR_BITS-1:0];
			end
			if (cmd.sh_clr) begin
				shift_q <= '0;
				bc_q    <= '0;
			end else if (cmd.sh_in) begin
				shift_q <= {shift_q[SHIFT_BITS-2:0], di_q};
				bc_q    <= bc_q + 1'b1;
			end else if (cmd.sh_left) begin
				shift_q <= {shift_q[SHIFT_BITS-2:0], 1'b0};
				bc_q    <= bc_rd_next;
			end else if (cmd.rd_load) begin
				shift_q <= load_val;
				bc_q    <= bc_rd_next;
				addr_q  <= addr_q + 1'b1;
			end

			if (cmd.fill_start) begin
				sweep_q <= '0;
			end else if (cmd.fill_step) begin
				sweep_q <= sweep_q + 1'b1;
			end
			if (wr_en) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	// Item latch, fill pattern and memory array: payload, no reset.
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			opcode_q <= op_t'(opcode);
			level_q  <= level;
		end
		if (cmd.fill_start) begin
			fill_data_q <= cmd.fill_ones ? '1 : shift_word;
		end
		if (wr_en) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= valid_q[idx] ? mem[idx] : '1;
	end

	always_comb begin
		st.opcode    = opcode_q;
		st.level     = level_q;
		st.cs        = cs_q;
		st.clk       = clk_q;
		st.di        = di_q;
		st.fresh     = fresh_q;
		st.busy_zero = (busy_q == '0);
		st.cmd_full  = (bc_q == BC_W'(2 + ADDR_BITS));
		st.word_full = (bc_q == BC_W'(WORD_BITS));
		st.rd_first  = (bc_q == '0);
		st.cmd_op    = shift_q[ADDR_BITS+1:ADDR_BITS];
		st.cmd_sub   = shift_q[ADDR_BITS-1:ADDR_BITS-2];
		st.lock      = lock_q;
		st.shift_msb = shift_q[SHIFT_BITS-1];
		st.fill_last = (sweep_q == MEM_AW'(DEPTH - 1));
	end

endmodule

// ===== src/mwee_ctrl.sv =====
module mwee_ctrl import mwee_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	output logic         data_out,
	output logic         ready_res,
	input  mwee_status_t st,
	output mwee_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RUN,
		S_ERASE,
		S_COMMIT,
		S_LOAD,
		S_FILL,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		M_IDLE,
		M_START,
		M_CMD,
		M_READ,
		M_WRITE,
		M_WRALL
	} mode_t;

	state_t state_q, state_d;
	mode_t  mode_q, mode_d;
	logic   out_valid_q, dout_q, rdy_q;
	logic   dout_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		mode_d   = mode_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = !out_valid_q || out_ready;
				if (in_valid && in_ready) begin
					cmd.item_load = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
				unique case (st.opcode)
					OP_CS: begin
						if (st.level != st.cs) begin
							cmd.set_cs = 1'b1;
							if (st.level) begin
								cmd.fresh_set = 1'b1;
								mode_d        = M_START;
							end else begin
								mode_d = M_IDLE;
							end
						end
					end
					OP_CLK: begin
						if (st.level != st.clk) begin
							cmd.set_clk = 1'b1;
							if (st.level) begin
								unique case (mode_q)
									M_START: begin
										if (st.di && st.busy_zero && !st.fresh) begin
											cmd.sh_clr = 1'b1;
											mode_d     = M_CMD;
										end
									end
									M_CMD: begin
										cmd.sh_in = 1'b1;
										state_d   = S_RUN;
									end
									M_READ: begin
										if (st.rd_first) begin
											state_d = S_LOAD;
										end else begin
											cmd.sh_left = 1'b1;
										end
									end
									M_WRITE, M_WRALL: begin
										cmd.sh_in = 1'b1;
										state_d   = S_COMMIT;
									end
									default: ;
								endcase
							end
						end
					end
					OP_DI: cmd.set_di = 1'b1;
					OP_TICK: begin
						cmd.tick      = 1'b1;
						cmd.fresh_clr = 1'b1;
					end
				endcase
			end
			S_RUN: begin
				state_d = S_DONE;
				if (st.cmd_full) begin
					cmd.run = 1'b1;
					mode_d  = M_IDLE;
					unique case (st.cmd_op)
						CMD_EXT: begin
							unique case (st.cmd_sub)
								SUB_LOCK:   cmd.lock_set = 1'b1;
								SUB_WRALL: begin
									cmd.sh_clr = 1'b1;
									mode_d     = M_WRALL;
								end
								SUB_ERAL: begin
									if (!st.lock) begin
										cmd.fill_start = 1'b1;
										cmd.fill_ones  = 1'b1;
										cmd.busy_sel   = BUSY_BULK;
										state_d        = S_FILL;
									end
								end
								SUB_UNLOCK: cmd.lock_clr = 1'b1;
							endcase
						end
						CMD_WRITE: begin
							cmd.sh_clr = 1'b1;
							mode_d     = M_WRITE;
						end
						CMD_READ: begin
							cmd.sh_clr = 1'b1;
							mode_d     = M_READ;
						end
						CMD_ERASE: begin
							if (!st.lock) begin
								state_d = S_ERASE;
							end
						end
					endcase
				end
			end
			S_ERASE: begin
				cmd.mem_wr   = 1'b1;
				cmd.mem_ones = 1'b1;
				cmd.busy_sel = BUSY_ERASE;
				state_d      = S_DONE;
			end
			S_COMMIT: begin
				state_d = S_DONE;
				if (st.word_full) begin
					mode_d = M_IDLE;
					if (!st.lock) begin
						if (mode_q == M_WRITE) begin
							cmd.mem_wr   = 1'b1;
							cmd.busy_sel = BUSY_WRITE;
						end else begin
							cmd.fill_start = 1'b1;
							cmd.busy_sel   = BUSY_BULK;
							state_d        = S_FILL;
						end
					end
				end
			end
			S_LOAD: begin
				cmd.rd_load = 1'b1;
				state_d     = S_DONE;
			end
			S_FILL: begin
				cmd.fill_step = 1'b1;
				if (st.fill_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		priority if (mode_q == M_READ) begin
			dout_d = st.shift_msb;
		end else if (mode_q == M_START) begin
			dout_d = st.busy_zero;
		end else begin
			dout_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= M_IDLE;
			out_valid_q <= 1'b0;
			dout_q      <= 1'b1;
			rdy_q       <= 1'b1;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_DONE) begin
				out_valid_q <= 1'b1;
				dout_q      <= dout_d;
				rdy_q       <= st.busy_zero;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = dout_q;
	assign ready_res = rdy_q;

endmodule
